FILE: rtl/core/lmsd_pkg.sv
// Package for the LED matrix scan driver: sizes, phase limits, pin word type
// and the built-in cross picture. No dependencies.
package lmsd_pkg;

    // matrix geometry; the frame store itself is always 16 x 16
    localparam int unsigned MATRIX_SIZE = 16;
    localparam int unsigned FRAME_ROWS  = 16;
    localparam int unsigned FRAME_BITS  = 16;
    localparam int unsigned ROW_W       = $clog2(FRAME_ROWS);
    localparam int unsigned BIT_W       = $clog2(FRAME_BITS);
    localparam int unsigned WIDX_W      = 5;
    localparam int unsigned PHASE_W     = 7;
    localparam int unsigned BYTE_W      = 8;

    // scan phase landmarks within one row
    localparam int unsigned CLEAR_END_I  = 2 * MATRIX_SIZE;
    localparam int unsigned LAST_PHASE_I = 4 * MATRIX_SIZE + 1;
    localparam logic [PHASE_W-1:0] CLEAR_END  = PHASE_W'(CLEAR_END_I);
    localparam logic [PHASE_W-1:0] SHIFT_BASE = PHASE_W'(CLEAR_END_I + 1);
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(LAST_PHASE_I);
    localparam logic [WIDX_W-1:0]  WIDX_LAST  = WIDX_W'(2 * MATRIX_SIZE - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(MATRIX_SIZE - 1);

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // one pin pattern
    typedef struct packed {
        logic column_data;
        logic column_latch;
        logic column_clock;
        logic row_data;
        logic row_latch;
        logic row_clock;
    } t_pins;

    // built-in cross picture, one row per entry
    function automatic logic [FRAME_BITS-1:0] cross_row(input logic [ROW_W-1:0] r);
        logic [FRAME_BITS-1:0] v;
        case (r)
            4'd0:    v = 16'h8101;
            4'd1:    v = 16'h4102;
            4'd2:    v = 16'h2104;
            4'd3:    v = 16'h1108;
            4'd4:    v = 16'h0910;
            4'd5:    v = 16'h0520;
            4'd6:    v = 16'h0340;
            4'd7:    v = 16'h0180;
            4'd8:    v = 16'hFFFF;
            4'd9:    v = 16'h0340;
            4'd10:   v = 16'h0520;
            4'd11:   v = 16'h0910;
            4'd12:   v = 16'h1108;
            4'd13:   v = 16'h2104;
            4'd14:   v = 16'h4102;
            4'd15:   v = 16'h8101;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/lmsd_if.sv
// Valid/ready channel interfaces of the LED matrix scan driver.
// Depends on nothing but the field widths fixed here.
interface lmsd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source(output valid, kind, data_byte, input ready);
    modport sink(input valid, kind, data_byte, output ready);
endinterface

interface lmsd_out_if;
    logic valid;
    logic ready;
    logic column_data;
    logic column_latch;
    logic column_clock;
    logic row_data;
    logic row_latch;
    logic row_clock;

    modport source(output valid, column_data, column_latch, column_clock, row_data,
                   row_latch, row_clock, input ready);
    modport sink(input valid, column_data, column_latch, column_clock, row_data,
                 row_latch, row_clock, output ready);
endinterface

FILE: rtl/core/led_matrix_scan_driver.sv
// LED matrix scan driver top level: frame store, scan counters, pin output buffer.
// Depends on lmsd_pkg and the channel interfaces in lmsd_if.sv.
//
// Usage
//   i_in carries words of two kinds. A byte word (kind 0) writes the next byte
//   of the 16 x 16 frame store, low byte then high byte of each row, the byte
//   index wrapping after the last row; it gives no output word. A tick word
//   (kind 1) steps the scan and gives exactly one pin word on o_out.
//   Each row takes 66 ticks: 32 to clear the columns, one column latch, 32 to
//   shift the row out, one tick latching both registers; then the next row.
//   Each pin word is registered before it shows on o_out, in the skid register if held.
//   Throughput: one word per cycle on i_in while i_in.ready is high;
//   the scan state and store update in the cycle of acceptance.
//   A two-entry output buffer (pin register plus skid register) lets i_in take
//   a word while a pin word still waits; i_in.ready drops only when both are
//   full, and pin words are held in order for as long as o_out.ready is low.
//   Reset (synchronous, active low) loads the cross picture, zeroes the byte
//   index, row and phase counters and empties the output buffer.
module led_matrix_scan_driver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmsd_in_if.sink    i_in,
    lmsd_out_if.source o_out
);
    import lmsd_pkg::*;

    logic [FRAME_BITS-1:0] r_frame [FRAME_ROWS];
    logic [WIDX_W-1:0]     r_widx, n_widx;
    logic [ROW_W-1:0]      r_scan_row, n_scan_row;
    logic [PHASE_W-1:0]    r_scan_phase, n_scan_phase;
    logic                  r_out_valid, r_skid_valid;
    t_pins                 r_out, r_skid;

    logic                  accept, push, pop;
    logic                  byte_wr;
    logic [ROW_W-1:0]      wr_row;
    logic [PHASE_W-1:0]    q;
    logic [BIT_W-1:0]      bit_j;
    logic [FRAME_BITS-1:0] cur_row;
    logic                  clk_ph;
    t_pins                 pins;

    // handshake
    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign push       = accept && (i_in.kind == KIND_TICK);
    assign byte_wr    = accept && (i_in.kind == KIND_BYTE);
    assign pop        = r_out_valid && o_out.ready;

    // byte index advance
    assign wr_row = r_widx[WIDX_W-1:1];
    always_comb begin
        n_widx = r_widx;
        if (byte_wr) begin
            n_widx = (r_widx == WIDX_LAST) ? '0 : r_widx + 1'b1;
        end
    end

    // pin pattern of the current phase and the next scan position
    assign q       = r_scan_phase - SHIFT_BASE;
    assign bit_j   = q[BIT_W:1];
    assign clk_ph  = q[0];
    assign cur_row = r_frame[r_scan_row];

    always_comb begin
        pins         = '0;
        n_scan_phase = r_scan_phase + 1'b1;
        n_scan_row   = r_scan_row;
        if (r_scan_phase < CLEAR_END) begin
            pins.column_clock = r_scan_phase[0];
        end else if (r_scan_phase == CLEAR_END) begin
            pins.column_latch = 1'b1;
        end else if (r_scan_phase < LAST_PHASE) begin
            pins.column_data  = cur_row[bit_j];
            pins.row_data     = (bit_j == r_scan_row);
            pins.column_clock = clk_ph;
            pins.row_clock    = clk_ph;
        end else begin
            pins.column_latch = 1'b1;
            pins.row_latch    = 1'b1;
            n_scan_phase      = '0;
            n_scan_row        = (r_scan_row >= ROW_LAST) ? '0 : r_scan_row + 1'b1;
        end
    end

    // frame store, loaded with the cross picture at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < FRAME_ROWS; r++) begin
                r_frame[r] <= cross_row(ROW_W'(r));
            end
        end else if (byte_wr) begin
            if (r_widx[0]) begin
                r_frame[wr_row][FRAME_BITS-1:BYTE_W] <= i_in.data_byte;
            end else begin
                r_frame[wr_row][BYTE_W-1:0] <= i_in.data_byte;
            end
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx       <= '0;
            r_scan_row   <= '0;
            r_scan_phase <= '0;
        end else begin
            r_widx <= n_widx;
            if (push) begin
                r_scan_row   <= n_scan_row;
                r_scan_phase <= n_scan_phase;
            end
        end
    end

    // output buffer: pin register with a skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload of the output buffer
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= pins;
            end else begin
                r_skid <= pins;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.column_data  = r_out.column_data;
    assign o_out.column_latch = r_out.column_latch;
    assign o_out.column_clock = r_out.column_clock;
    assign o_out.row_data     = r_out.row_data;
    assign o_out.row_latch    = r_out.row_latch;
    assign o_out.row_clock    = r_out.row_clock;

    // checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while pin register empty");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_phase <= LAST_PHASE)
        else $error("scan phase beyond last tick of row");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_row <= ROW_LAST)
        else $error("scan row beyond matrix");

    a_byte_keeps_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_BYTE) |=> ($stable(r_scan_phase) && $stable(r_scan_row)))
        else $error("byte word moved the scan");

    a_latch_no_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.column_latch) |-> (!r_out.column_clock && !r_out.row_clock))
        else $error("latch raised together with a shift clock");

endmodule
